// File: rtl/windowed_rate_averager_core_defines.svh
// Assertion macros shared by the windowed rate averager modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef WINDOWED_RATE_AVERAGER_CORE_DEFINES_SVH
`define WINDOWED_RATE_AVERAGER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("windowed_rate_averager_core: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("windowed_rate_averager_core: next-cycle check failed");

`endif

// File: rtl/wra_pkg.sv
// Shared types, constants and the microcode table of the windowed rate averager.
// No dependencies; every other module file imports this package.
package wra_pkg;

  localparam int READ_W = 48;
  localparam int RATE_W = 49;
  localparam int AVG_W  = 40;
  localparam int IVL_W  = 12;
  // Wide enough for the largest window (1024) times 1000 and for the interval.
  localparam int DVS_W  = 20;
  localparam int STEP_W = 4;
  localparam int MS_DIV = 1000;

  localparam logic [IVL_W-1:0] IVL_RESET = 12'd20;

  localparam int SHORT_WINDOW_DEF = 3;
  localparam int MID_WINDOW_DEF   = 15;
  localparam int LONG_WINDOW_DEF  = 45;

  // Program addresses used as jump targets.
  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RATE_WAIT = 4'd2;
  localparam logic [STEP_W-1:0] STEP_S_WAIT    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_M_WAIT    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_L_WAIT    = 4'd14;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd15;
  localparam logic [STEP_W-1:0] STEP_LAST      = 4'd15;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_RATE_DIV,
    OP_RATE_END,
    OP_RD_OLD,
    OP_UPDATE,
    OP_MEAN_DIV,
    OP_MEAN_END,
    OP_EMIT
  } wra_op_e;

  typedef enum logic [1:0] {
    WIN_SHORT,
    WIN_MID,
    WIN_LONG
  } wra_win_e;

  // Hold conditions: while true the step jumps to its target instead of executing.
  typedef enum logic [1:0] {
    C_NONE,
    C_IN,
    C_DIV,
    C_OUT
  } wra_cond_e;

  typedef struct packed {
    wra_op_e             op;
    wra_win_e            win;
    wra_cond_e           cond;
    logic [STEP_W-1:0]   target;
  } wra_uword_t;

  typedef struct packed {
    wra_op_e  op;
    wra_win_e win;
    logic     fire;
  } wra_seq_ctl_t;

  typedef struct packed {
    logic rd;
    logic upd;
  } wra_ring_ctl_t;

  // Microcode table: one control word per program step.
  function automatic wra_uword_t wra_rom(input logic [STEP_W-1:0] step);
    wra_uword_t uw;
    case (step)
      4'd0:    uw = '{OP_ACCEPT,   WIN_SHORT, C_IN,   STEP_IDLE};
      4'd1:    uw = '{OP_RATE_DIV, WIN_SHORT, C_NONE, STEP_IDLE};
      4'd2:    uw = '{OP_RATE_END, WIN_SHORT, C_DIV,  STEP_RATE_WAIT};
      4'd3:    uw = '{OP_RD_OLD,   WIN_SHORT, C_NONE, STEP_IDLE};
      4'd4:    uw = '{OP_UPDATE,   WIN_SHORT, C_NONE, STEP_IDLE};
      4'd5:    uw = '{OP_MEAN_DIV, WIN_SHORT, C_NONE, STEP_IDLE};
      4'd6:    uw = '{OP_MEAN_END, WIN_SHORT, C_DIV,  STEP_S_WAIT};
      4'd7:    uw = '{OP_RD_OLD,   WIN_MID,   C_NONE, STEP_IDLE};
      4'd8:    uw = '{OP_UPDATE,   WIN_MID,   C_NONE, STEP_IDLE};
      4'd9:    uw = '{OP_MEAN_DIV, WIN_MID,   C_NONE, STEP_IDLE};
      4'd10:   uw = '{OP_MEAN_END, WIN_MID,   C_DIV,  STEP_M_WAIT};
      4'd11:   uw = '{OP_RD_OLD,   WIN_LONG,  C_NONE, STEP_IDLE};
      4'd12:   uw = '{OP_UPDATE,   WIN_LONG,  C_NONE, STEP_IDLE};
      4'd13:   uw = '{OP_MEAN_DIV, WIN_LONG,  C_NONE, STEP_IDLE};
      4'd14:   uw = '{OP_MEAN_END, WIN_LONG,  C_DIV,  STEP_L_WAIT};
      4'd15:   uw = '{OP_EMIT,     WIN_SHORT, C_OUT,  STEP_EMIT};
      default: uw = '{OP_ACCEPT,   WIN_SHORT, C_IN,   STEP_IDLE};
    endcase
    return uw;
  endfunction

endpackage

// File: rtl/wra_div.sv
// Shared signed-by-unsigned restoring divider, one quotient bit per cycle.
// Depends on wra_pkg and the assertion macro header.
`include "windowed_rate_averager_core_defines.svh"

module wra_div import wra_pkg::*; #(
  parameter int DIV_W = 55
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic                    busy_o,
  output logic signed [DIV_W-1:0] quotient_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DIV_W-1:0] mag;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Magnitude of the dividend; the quotient takes the dividend's sign.
  assign mag = dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);

  // One restoring step: shift in the next dividend bit and try the subtraction.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIV_W);
      quo_d  = mag;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[DIV_W-1];
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? -signed'(quo_q) : signed'(quo_q);

  `WRA_ASSERT_IMP(a_div_start_when_idle, start_i, !busy_q)
  `WRA_ASSERT_NXT(a_div_ends_on_count, busy_q && (cnt_q == CW'(1)) && !start_i, !busy_q)

endmodule

// File: rtl/wra_ring.sv
// One averaging window: circular rate memory, running sum, fill count and write slot.
// Depends on wra_pkg and the assertion macro header.
`include "windowed_rate_averager_core_defines.svh"

module wra_ring import wra_pkg::*; #(
  parameter int WIN   = SHORT_WINDOW_DEF,
  parameter int SUM_W = RATE_W + $clog2(SHORT_WINDOW_DEF + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wra_ring_ctl_t              ctl_i,
  input  logic signed [RATE_W-1:0]   rate_i,
  output logic signed [SUM_W-1:0]    sum_o,
  output logic [$clog2(WIN+1)-1:0]   fill_o
);

  localparam int FW = $clog2(WIN + 1);
  localparam int PW = (WIN > 1) ? $clog2(WIN) : 1;

  logic signed [RATE_W-1:0] ring_mem [WIN];
  logic signed [RATE_W-1:0] old_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [SUM_W-1:0]  old_ext;
  logic [FW-1:0]            fill_q, fill_d;
  logic [PW-1:0]            pos_q, pos_d;
  logic                     full;

  // Ring memory: the oldest entry is read in the step before the slot is overwritten.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      old_q <= ring_mem[pos_q];
    end
    if (ctl_i.upd) begin
      ring_mem[pos_q] <= rate_i;
    end
  end

  // Once the window is full the leaving entry comes off the sum.
  assign full    = fill_q == FW'(WIN);
  assign old_ext = full ? SUM_W'(old_q) : SUM_W'(0);

  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    pos_d  = pos_q;
    if (ctl_i.upd) begin
      sum_d  = sum_q - old_ext + SUM_W'(rate_i);
      fill_d = full ? fill_q : fill_q + 1'b1;
      pos_d  = (pos_q == PW'(WIN - 1)) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      pos_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      pos_q  <= pos_d;
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

  `WRA_ASSERT_IMP(a_ring_fill_bounded, 1'b1, (fill_q <= FW'(WIN)) && (pos_q <= PW'(WIN - 1)))

endmodule

// File: rtl/wra_seq.sv
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on wra_pkg (program table) and the assertion macro header.
`include "windowed_rate_averager_core_defines.svh"

module wra_seq import wra_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         div_busy_i,
  input  logic         out_hold_i,
  output wra_seq_ctl_t ctl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  wra_uword_t        uw;
  logic              hold;

  assign uw = wra_rom(step_q);

  // A step holds on its condition and jumps to its target; otherwise it executes.
  always_comb begin
    case (uw.cond)
      C_NONE:  hold = 1'b0;
      C_IN:    hold = !in_valid_i;
      C_DIV:   hold = div_busy_i;
      C_OUT:   hold = out_hold_i;
      default: hold = 1'b0;
    endcase
    if (hold) begin
      step_d = uw.target;
    end else if (step_q == STEP_LAST) begin
      step_d = STEP_IDLE;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o.op   = uw.op;
  assign ctl_o.win  = uw.win;
  assign ctl_o.fire = !hold;

  `WRA_ASSERT_NXT(a_seq_start_then_wait, ctl_o.fire && ((ctl_o.op == OP_RATE_DIV) || (ctl_o.op == OP_MEAN_DIV)), div_busy_i && (uw.cond == C_DIV))

endmodule

// File: rtl/windowed_rate_averager_core.sv
// Top level of the windowed rate averager: ports, rate datapath, output register.
// Depends on wra_pkg, wra_seq, wra_div, wra_ring and the assertion macro header.
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_axis    in         tdata: usage_reading[47:0]
//  m_axis    out        tdata: short_average, mid_average, long_average (40 bits each)
//  cfg       in         data: interval_seconds[11:0]
//
// A beat is accepted only at the idle step, and the next beat waits until the program
// has run through; the shared bit-serial divider runs four divisions per beat, and DIV_W
// is the widest window sum width (55 bits with 3/15/45 windows).
// Reset is asynchronous and active low; windows start empty and the interval is 20.
// A result waits in the output register while the next beat is accepted and worked on;
// only the final emit step stalls on a full output register.
`include "windowed_rate_averager_core_defines.svh"

module windowed_rate_averager_core import wra_pkg::*; #(
  parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
  parameter int MID_WINDOW   = MID_WINDOW_DEF,
  parameter int LONG_WINDOW  = LONG_WINDOW_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // usage_reading[47:0]
  input  logic [47:0]          s_axis_tdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // short_average[39:0], mid_average[79:40], long_average[119:80]
  output logic [119:0]         m_axis_tdata_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  input  logic [IVL_W-1:0]     cfg_data_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o
);

  localparam int S_SUM_W = RATE_W + $clog2(SHORT_WINDOW + 1);
  localparam int M_SUM_W = RATE_W + $clog2(MID_WINDOW + 1);
  localparam int L_SUM_W = RATE_W + $clog2(LONG_WINDOW + 1);
  localparam int SM_W    = (S_SUM_W > M_SUM_W) ? S_SUM_W : M_SUM_W;
  localparam int DIV_W   = (SM_W > L_SUM_W) ? SM_W : L_SUM_W;
  localparam int S_FW    = $clog2(SHORT_WINDOW + 1);
  localparam int M_FW    = $clog2(MID_WINDOW + 1);
  localparam int L_FW    = $clog2(LONG_WINDOW + 1);

  wra_seq_ctl_t             ctl;
  wra_ring_ctl_t            s_ctl, m_ctl, l_ctl;
  logic                     div_start;
  logic                     div_busy;
  logic signed [DIV_W-1:0]  div_dividend;
  logic [DVS_W-1:0]         div_divisor;
  logic signed [DIV_W-1:0]  div_quot;
  logic signed [S_SUM_W-1:0] s_sum;
  logic signed [M_SUM_W-1:0] m_sum;
  logic signed [L_SUM_W-1:0] l_sum;
  logic [S_FW-1:0]          s_fill;
  logic [M_FW-1:0]          m_fill;
  logic [L_FW-1:0]          l_fill;
  logic [DVS_W-1:0]         fill_sel;
  logic signed [DIV_W-1:0]  sum_sel;
  logic                     in_accept;
  logic                     out_hold;

  logic [IVL_W-1:0]         ivl_q;
  logic [READ_W-1:0]        prev_q;
  logic                     prev_zero_q;
  logic signed [RATE_W-1:0] delta_q;
  logic signed [RATE_W-1:0] rate_q;
  logic signed [AVG_W-1:0]  s_avg_q, m_avg_q, l_avg_q;
  logic [119:0]             out_data_q;
  logic                     out_valid_q;

  // Sequencer.
  assign out_hold = out_valid_q && !m_axis_tready_i;

  wra_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .div_busy_i (div_busy),
    .out_hold_i (out_hold),
    .ctl_o      (ctl)
  );

  assign s_axis_tready_o = ctl.op == OP_ACCEPT;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Per-window strobes decoded from the control word.
  always_comb begin
    s_ctl = '0;
    m_ctl = '0;
    l_ctl = '0;
    case (ctl.win)
      WIN_SHORT: begin
        s_ctl.rd  = ctl.fire && (ctl.op == OP_RD_OLD);
        s_ctl.upd = ctl.fire && (ctl.op == OP_UPDATE);
      end
      WIN_MID: begin
        m_ctl.rd  = ctl.fire && (ctl.op == OP_RD_OLD);
        m_ctl.upd = ctl.fire && (ctl.op == OP_UPDATE);
      end
      WIN_LONG: begin
        l_ctl.rd  = ctl.fire && (ctl.op == OP_RD_OLD);
        l_ctl.upd = ctl.fire && (ctl.op == OP_UPDATE);
      end
      default: begin
        s_ctl = '0;
      end
    endcase
  end

  wra_ring #(.WIN(SHORT_WINDOW), .SUM_W(S_SUM_W)) u_ring_short (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (s_ctl), .rate_i (rate_q),
    .sum_o (s_sum), .fill_o (s_fill)
  );

  wra_ring #(.WIN(MID_WINDOW), .SUM_W(M_SUM_W)) u_ring_mid (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (m_ctl), .rate_i (rate_q),
    .sum_o (m_sum), .fill_o (m_fill)
  );

  wra_ring #(.WIN(LONG_WINDOW), .SUM_W(L_SUM_W)) u_ring_long (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (l_ctl), .rate_i (rate_q),
    .sum_o (l_sum), .fill_o (l_fill)
  );

  // Divider operands. The mean and the division by 1000 fold into one division by
  // fill * 1000, which truncates the same way as the two steps in turn.
  always_comb begin
    case (ctl.win)
      WIN_SHORT: begin
        fill_sel = DVS_W'(s_fill);
        sum_sel  = DIV_W'(s_sum);
      end
      WIN_MID: begin
        fill_sel = DVS_W'(m_fill);
        sum_sel  = DIV_W'(m_sum);
      end
      WIN_LONG: begin
        fill_sel = DVS_W'(l_fill);
        sum_sel  = DIV_W'(l_sum);
      end
      default: begin
        fill_sel = DVS_W'(s_fill);
        sum_sel  = DIV_W'(s_sum);
      end
    endcase
    if (ctl.op == OP_RATE_DIV) begin
      div_dividend = DIV_W'(delta_q);
      div_divisor  = (ivl_q == '0) ? DVS_W'(1) : DVS_W'(ivl_q);
    end else begin
      div_dividend = sum_sel;
      div_divisor  = DVS_W'(fill_sel * DVS_W'(MS_DIV));
    end
  end

  assign div_start = ctl.fire && ((ctl.op == OP_RATE_DIV) || (ctl.op == OP_MEAN_DIV));

  wra_div #(.DIV_W(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // Control state: interval register, previous reading and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivl_q       <= IVL_RESET;
      prev_q      <= '0;
      prev_zero_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ivl_q <= cfg_data_i;
      end
      if (in_accept) begin
        prev_q      <= s_axis_tdata_i;
        prev_zero_q <= prev_q == '0;
      end
      if (ctl.fire && (ctl.op == OP_EMIT)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: delta, rate, per-window averages and the output beat.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      delta_q <= signed'({1'b0, s_axis_tdata_i}) - signed'({1'b0, prev_q});
    end
    if (ctl.fire && (ctl.op == OP_RATE_END)) begin
      rate_q <= prev_zero_q ? '0 : div_quot[RATE_W-1:0];
    end
    if (ctl.fire && (ctl.op == OP_MEAN_END)) begin
      case (ctl.win)
        WIN_SHORT: s_avg_q <= div_quot[AVG_W-1:0];
        WIN_MID:   m_avg_q <= div_quot[AVG_W-1:0];
        WIN_LONG:  l_avg_q <= div_quot[AVG_W-1:0];
        default:   s_avg_q <= div_quot[AVG_W-1:0];
      endcase
    end
    if (ctl.fire && (ctl.op == OP_EMIT)) begin
      out_data_q <= {l_avg_q, m_avg_q, s_avg_q};
    end
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

  `WRA_ASSERT_IMP(a_top_idle_divider, s_axis_tready_o, !div_busy)
  `WRA_ASSERT_NXT(a_top_emit_shows, ctl.fire && (ctl.op == OP_EMIT), m_axis_tvalid_o)

endmodule
